// File: hdl/pid_with_filtered_derivative_macros.svh
// Assertion helpers used by the checker file.
`ifndef PID_WITH_FILTERED_DERIVATIVE_MACROS_SVH
`define PID_WITH_FILTERED_DERIVATIVE_MACROS_SVH

// Clocked check, switched off while reset is held.
`define PIDFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define PIDFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/pidfd_pkg.sv
package pidfd_pkg;

    localparam int REG_IDX_W = 3;

    typedef enum logic {
        OP_COMPUTE = 1'b0,
        OP_CLEAR   = 1'b1
    } t_op;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_FILTER_ALPHA  = 3'd3,
        REG_INTEG_FLOOR   = 3'd4,
        REG_INTEG_CEILING = 3'd5,
        REG_DRIVE_FLOOR   = 3'd6,
        REG_DRIVE_CEILING = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_INTEG,
        ST_DIV,
        ST_FILT_A,
        ST_FILT_B,
        ST_FILT_SUM,
        ST_P_TERM,
        ST_I_TERM,
        ST_D_TERM,
        ST_DONE
    } t_state;

endpackage

// File: hdl/pidfd_div.sv
// Bit-serial restoring divider: quotient = trunc(+/- num_mag * 2^FRAC / den).
module pidfd_div #(
    parameter int NUM_W = 33,
    parameter int FRAC  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [NUM_W-1:0]            i_num_mag,
    input  logic                        i_neg,
    input  logic [FRAC:0]               i_den,
    output logic                        o_done,
    output logic signed [NUM_W+FRAC:0]  o_quot
);

    localparam int DEN_W = FRAC + 1;
    localparam int QW    = NUM_W + FRAC;
    localparam int CNT_W = $clog2(QW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [QW-1:0]    r_dvd;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             ge;

    assign trial     = {r_rem, r_dvd[QW-1]};
    assign ge        = (trial >= {1'b0, r_den});
    assign trial_sub = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in from the bottom as the dividend leaves the top.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_num_mag, {FRAC{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[QW-2:0], ge};
            r_rem <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});

endmodule

// File: hdl/pid_with_filtered_derivative.sv
// Channel    Direction  Handshake                  Payload
// ---------  ---------  -------------------------  -----------------------------------------
// input      in         i_in_valid / o_in_ready    i_op, i_target, i_sensed, i_step_time
// result     out        o_out_valid / i_out_ready  o_drive, o_loop_error, o_integ_value
// config     in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A compute transaction steps through the difference, the integration, the bit-serial slope
// divider (one quotient bit a cycle), the filter and the three terms before its result;
// the six products share one multiplier. A zero time step skips the divider; a clear
// transaction goes straight from acceptance to the done state.
// Reset is synchronous and active low; it restores the register defaults and zeroes state.
// A pending result waits while the next transaction is taken; a finished one holds until free.
module pid_with_filtered_derivative #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_op,
    input  logic signed [DATA_WIDTH-1:0]          i_target,
    input  logic signed [DATA_WIDTH-1:0]          i_sensed,
    input  logic [FRAC_BITS:0]                    i_step_time,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [DATA_WIDTH-1:0]          o_drive,
    output logic signed [DATA_WIDTH-1:0]          o_loop_error,
    output logic signed [DATA_WIDTH-1:0]          o_integ_value,
    // configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pidfd_pkg::REG_IDX_W-1:0]       i_cfg_index,
    input  logic [((DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS + 1)-1:0] i_cfg_data
);

    localparam int W     = DATA_WIDTH;
    localparam int F     = FRAC_BITS;
    // Multiplier operand width: wide enough for a data word and for a signed weight.
    localparam int MW    = (W > F + 1) ? W : F + 2;
    localparam int PW    = 2 * MW;
    // Accumulator width: holds any product, filter sum or three-term sum.
    localparam int AW    = 2 * MW + 2;
    localparam int NUM_W = W + 1;
    localparam int QW    = NUM_W + F;

    localparam logic signed [AW-1:0] SAT_HI = {{(AW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;
    localparam logic [F:0]           ONE_A  = {1'b1, {F{1'b0}}};
    localparam logic signed [W-1:0]  W_MAX  = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0]  W_MIN  = {1'b1, {(W - 1){1'b0}}};

    // Saturate a wide signed value to one data word.
    function automatic logic signed [W-1:0] f_sat(input logic signed [AW-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[W-1:0];
        end
        return v[W-1:0];
    endfunction

    // Fixed-point product: floor shift by the fraction width, then saturate.
    function automatic logic signed [W-1:0] f_fx(input logic signed [PW-1:0] p);
        logic signed [AW-1:0] ext;
        ext = AW'(p);
        return f_sat(ext >>> F);
    endfunction

    // Apply the ceiling first, then the floor, so crossed limits give the floor.
    function automatic logic signed [W-1:0] f_limit(input logic signed [W-1:0] v,
                                                    input logic signed [W-1:0] lo,
                                                    input logic signed [W-1:0] hi);
        logic signed [W-1:0] t;
        t = (v > hi) ? hi : v;
        return (t < lo) ? lo : t;
    endfunction

    // sequencer
    pidfd_pkg::t_state r_state;
    pidfd_pkg::t_state n_state;
    logic              r_clear;

    // configuration registers
    logic signed [W-1:0] r_kp;
    logic signed [W-1:0] r_ki;
    logic signed [W-1:0] r_kd;
    logic [F:0]          r_alpha;
    logic signed [W-1:0] r_ifloor;
    logic signed [W-1:0] r_iceil;
    logic signed [W-1:0] r_dfloor;
    logic signed [W-1:0] r_dceil;

    // controller state
    logic signed [W-1:0] r_prev;
    logic signed [W-1:0] r_integ;
    logic signed [W-1:0] r_smooth;

    // working registers
    logic signed [W-1:0]  r_err;
    logic [F:0]           r_dt;
    logic signed [W-1:0]  r_slope;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;

    // result register
    logic                r_out_valid;
    logic signed [W-1:0] r_drive;
    logic signed [W-1:0] r_out_err;
    logic signed [W-1:0] r_out_integ;

    logic                in_take;
    logic                out_free;
    logic                div_start;
    logic                div_done;
    logic signed [QW:0]  div_quot;
    logic signed [W:0]   diff;
    logic [W:0]          diff_mag;
    logic [F:0]          alpha_c;
    logic [F:0]          alpha_rest;
    logic signed [MW-1:0] m_a;
    logic signed [MW-1:0] m_b;
    logic signed [PW-1:0] m_prod;

    assign o_in_ready  = (r_state == pidfd_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Slope numerator: difference of successive errors, one bit wider than a word.
    assign diff       = (W + 1)'(r_err) - (W + 1)'(r_prev);
    assign diff_mag   = diff[W] ? -diff : diff;
    assign div_start  = (r_state == pidfd_pkg::ST_DIFF) && (r_dt != '0);

    // Clamp the filter weight to one; the old value keeps the remainder.
    assign alpha_c    = (r_alpha > ONE_A) ? ONE_A : r_alpha;
    assign alpha_rest = ONE_A - alpha_c;

    pidfd_div #(
        .NUM_W (NUM_W),
        .FRAC  (F)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_num_mag (diff_mag),
        .i_neg     (diff[W]),
        .i_den     (r_dt),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // Shared multiplier: pick the operand pair of the current step.
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            pidfd_pkg::ST_DIFF: begin
                m_a = MW'(r_err);
                m_b = MW'({1'b0, r_dt});
            end
            pidfd_pkg::ST_FILT_A: begin
                m_a = MW'({1'b0, alpha_c});
                m_b = MW'(r_slope);
            end
            pidfd_pkg::ST_FILT_B: begin
                m_a = MW'({1'b0, alpha_rest});
                m_b = MW'(r_smooth);
            end
            pidfd_pkg::ST_FILT_SUM: begin
                m_a = MW'(r_kp);
                m_b = MW'(r_err);
            end
            pidfd_pkg::ST_P_TERM: begin
                m_a = MW'(r_ki);
                m_b = MW'(r_integ);
            end
            pidfd_pkg::ST_I_TERM: begin
                m_a = MW'(r_kd);
                m_b = MW'(r_smooth);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_prod = m_a * m_b;

    // Next step of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pidfd_pkg::ST_IDLE: begin
                if (in_take) begin
                    n_state = (i_op == pidfd_pkg::OP_CLEAR) ? pidfd_pkg::ST_DONE
                                                            : pidfd_pkg::ST_DIFF;
                end
            end
            pidfd_pkg::ST_DIFF:     n_state = pidfd_pkg::ST_INTEG;
            pidfd_pkg::ST_INTEG: begin
                n_state = (r_dt == '0) ? pidfd_pkg::ST_FILT_A : pidfd_pkg::ST_DIV;
            end
            pidfd_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = pidfd_pkg::ST_FILT_A;
                end
            end
            pidfd_pkg::ST_FILT_A:   n_state = pidfd_pkg::ST_FILT_B;
            pidfd_pkg::ST_FILT_B:   n_state = pidfd_pkg::ST_FILT_SUM;
            pidfd_pkg::ST_FILT_SUM: n_state = pidfd_pkg::ST_P_TERM;
            pidfd_pkg::ST_P_TERM:   n_state = pidfd_pkg::ST_I_TERM;
            pidfd_pkg::ST_I_TERM:   n_state = pidfd_pkg::ST_D_TERM;
            pidfd_pkg::ST_D_TERM:   n_state = pidfd_pkg::ST_DONE;
            pidfd_pkg::ST_DONE: begin
                // hold until the result register can take this transaction
                if (out_free) begin
                    n_state = pidfd_pkg::ST_IDLE;
                end
            end
            default:                n_state = pidfd_pkg::ST_IDLE;
        endcase
    end

    // Control, configuration and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pidfd_pkg::ST_IDLE;
            r_clear     <= 1'b0;
            r_out_valid <= 1'b0;
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_alpha     <= ONE_A;
            r_ifloor    <= W_MIN;
            r_iceil     <= W_MAX;
            r_dfloor    <= W_MIN;
            r_dceil     <= W_MAX;
            r_prev      <= '0;
            r_integ     <= '0;
            r_smooth    <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (pidfd_pkg::t_reg_idx'(i_cfg_index))
                    pidfd_pkg::REG_PROP_GAIN:     r_kp     <= i_cfg_data[W-1:0];
                    pidfd_pkg::REG_INTEG_GAIN:    r_ki     <= i_cfg_data[W-1:0];
                    pidfd_pkg::REG_DERIV_GAIN:    r_kd     <= i_cfg_data[W-1:0];
                    pidfd_pkg::REG_FILTER_ALPHA:  r_alpha  <= i_cfg_data[F:0];
                    pidfd_pkg::REG_INTEG_FLOOR:   r_ifloor <= i_cfg_data[W-1:0];
                    pidfd_pkg::REG_INTEG_CEILING: r_iceil  <= i_cfg_data[W-1:0];
                    pidfd_pkg::REG_DRIVE_FLOOR:   r_dfloor <= i_cfg_data[W-1:0];
                    pidfd_pkg::REG_DRIVE_CEILING: r_dceil  <= i_cfg_data[W-1:0];
                    default: ;
                endcase
            end

            // load a finished transaction, otherwise drop the result once taken
            if ((r_state == pidfd_pkg::ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                pidfd_pkg::ST_IDLE: begin
                    if (in_take) begin
                        r_clear <= (i_op == pidfd_pkg::OP_CLEAR);
                        if (i_op == pidfd_pkg::OP_CLEAR) begin
                            r_prev   <= '0;
                            r_integ  <= '0;
                            r_smooth <= '0;
                        end
                    end
                end
                pidfd_pkg::ST_INTEG: begin
                    // accumulate error * dt, saturate, then apply anti-windup limits
                    r_integ <= f_limit(f_sat(AW'(r_integ) + (AW'(r_prod) >>> F)),
                                       r_ifloor, r_iceil);
                end
                pidfd_pkg::ST_FILT_SUM: begin
                    r_smooth <= f_sat((r_acc + AW'(r_prod)) >>> F);
                end
                pidfd_pkg::ST_DONE: begin
                    if (out_free && !r_clear) begin
                        r_prev <= r_err;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath payload; no reset needed.
    always_ff @(posedge i_clk) begin
        r_prod <= m_prod;

        case (r_state)
            pidfd_pkg::ST_IDLE: begin
                if (in_take) begin
                    r_err <= f_sat(AW'(i_target) - AW'(i_sensed));
                    r_dt  <= i_step_time;
                end
            end
            pidfd_pkg::ST_DIFF: begin
                // a zero time step gives a flat slope and bypasses the divider
                if (r_dt == '0) begin
                    r_slope <= '0;
                end
            end
            pidfd_pkg::ST_DIV: begin
                if (div_done) begin
                    r_slope <= f_sat(AW'(div_quot));
                end
            end
            pidfd_pkg::ST_FILT_B: begin
                r_acc <= AW'(r_prod);
            end
            pidfd_pkg::ST_P_TERM: begin
                r_acc <= AW'(f_fx(r_prod));
            end
            pidfd_pkg::ST_I_TERM,
            pidfd_pkg::ST_D_TERM: begin
                r_acc <= r_acc + AW'(f_fx(r_prod));
            end
            pidfd_pkg::ST_DONE: begin
                if (out_free) begin
                    if (r_clear) begin
                        r_drive     <= '0;
                        r_out_err   <= '0;
                        r_out_integ <= '0;
                    end else begin
                        r_drive     <= f_limit(f_sat(r_acc), r_dfloor, r_dceil);
                        r_out_err   <= r_err;
                        r_out_integ <= r_integ;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_drive;
    assign o_loop_error  = r_out_err;
    assign o_integ_value = r_out_integ;

endmodule

// File: hdl/pidfd_checker.sv
`include "pid_with_filtered_derivative_macros.svh"

module pidfd_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         i_op,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [DATA_WIDTH-1:0] o_drive,
    input logic signed [DATA_WIDTH-1:0] o_loop_error,
    input logic signed [DATA_WIDTH-1:0] o_integ_value
);

    // hold a result until it is taken
    `PIDFD_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped before it was taken")

    // a compute transaction leaves the block busy after it is taken
    `PIDFD_ASSERT(a_busy_after_compute, i_in_valid && o_in_ready && (i_op == pidfd_pkg::OP_COMPUTE) |=> !o_in_ready, "ready straight after a compute transaction")

    // a clear into an empty block returns all-zero fields through the done state and the result register
    `PIDFD_ASSERT(a_clear_zero, i_in_valid && o_in_ready && (i_op == pidfd_pkg::OP_CLEAR) && !o_out_valid |=> ##1 (o_out_valid && o_drive == '0 && o_loop_error == '0 && o_integ_value == '0), "clear result not zero")

    // no stale result right after reset
    `PIDFD_ASSERT(a_quiet_after_reset, $rose(i_rst_n) |-> !o_out_valid, "result valid after reset")

    // reset drops any pending result
    `PIDFD_ASSERT_ALWAYS(a_reset_drops_valid, !i_rst_n |=> !o_out_valid, "result valid during reset")

endmodule

bind pid_with_filtered_derivative pidfd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pidfd_checker (.*);
